@@ src/sorted_priority_ready_queue_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Sorted priority ready queue assertion macros
// Shared property forms for the queue's port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Capacity, widths, command and status codes, and shared types.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Number of entry cells in the chain.
	localparam int DEPTH = 16;
	// Width of the held count, able to hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Command codes.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// One stored queue entry.
	typedef struct packed {
		logic [7:0] id;
		logic [7:0] prio;
	} entry_t;

	// Per-cell control from the queue controller.
	typedef struct packed {
		logic ins;     // insert moves through the chain this cycle
		logic rem;     // remove shifts the chain toward the head
		logic occ;     // this cell holds a live entry
		logic left_gt; // the new entry also outranks the left neighbor
	} cell_ctrl_t;

endpackage

@@ src/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// Queue command channel
// Valid/ready channel carrying one insert or remove command.
// ----------------------------------------------------------------------------
interface spq_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] process_id;
	logic [7:0] process_priority;

	modport source (output valid, cmd, process_id, process_priority, input ready);
	modport sink (input valid, cmd, process_id, process_priority, output ready);
endinterface

@@ src/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// Queue result channel
// Valid/ready channel carrying one status and popped entry per command.
// ----------------------------------------------------------------------------
interface spq_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] popped_id;
	logic [7:0] popped_priority;
	logic [4:0] entry_count;

	modport source (output valid, status, popped_id, popped_priority, entry_count,
		input ready);
	modport sink (input valid, status, popped_id, popped_priority, entry_count,
		output ready);
endinterface

@@ src/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted queue cell
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor, and on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_entry,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       gt
);

	entry_t entry_q;

	// The new entry lands at or before this cell when the cell is empty or
	// strictly outranked; equal priority stays ahead of the newcomer.
	assign gt = !ctrl.occ || (new_entry.prio > entry_q.prio);

	// Entry storage: shift right on insert, shift left on remove.
	always_ff @(posedge clk) begin
		if (ctrl.ins && gt) begin
			entry_q <= ctrl.left_gt ? left_entry : new_entry;
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ src/sorted_priority_ready_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted priority ready queue
// Priority queue of process entries held in a row of cells, sorted by
// descending priority with ties in arrival order.
//
//   Channel  Direction  Carries
//   in_ch    sink       cmd, process_id, process_priority
//   out_ch   source     status, popped_id, popped_priority, entry_count
//
// Every cell compares the new priority with its own at once and the chain
// shifts in the same cycle as the transfer, so one command per cycle is
// sustained while results are taken. The result is registered and appears in
// the cycle after the transfer. The output register frees in the cycle it is
// taken, so a stalled result only holds off the next command. Reset empties
// the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_ready_queue_unit
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             out_valid_q;
	logic [1:0]       status_q;
	entry_t           popped_q;
	logic [4:0]       entry_count_q;

	logic       accept;
	logic       full;
	logic       empty;
	logic       do_ins;
	logic       do_rem;
	logic [1:0] status_next;
	entry_t     new_entry;

	entry_t     cell_entry [DEPTH];
	logic       cell_gt [DEPTH];
	cell_ctrl_t cell_ctrl [DEPTH];

	// A command is taken whenever the result register is free or being drained.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_ins = accept && (in_ch.cmd == CMD_INSERT) && !full;
	assign do_rem = accept && (in_ch.cmd == CMD_REMOVE) && !empty;

	assign new_entry.id   = in_ch.process_id;
	assign new_entry.prio = in_ch.process_priority;

	// Cell row with neighbor links; the ends see an empty neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_ctrl[i].ins     = do_ins;
		assign cell_ctrl[i].rem     = do_rem;
		assign cell_ctrl[i].occ     = (count_q > CNT_W'(i));
		if (i == 0) begin : g_head
			assign cell_ctrl[i].left_gt = 1'b0;
		end else begin : g_body
			assign cell_ctrl[i].left_gt = cell_gt[i-1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl[i]),
			.new_entry   (new_entry),
			.left_entry  ((i == 0) ? entry_t'('0) : cell_entry[(i == 0) ? 0 : i-1]),
			.right_entry ((i == DEPTH-1) ? entry_t'('0)
				: cell_entry[(i == DEPTH-1) ? i : i+1]),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i])
		);
	end

	// Count after this command and its status.
	always_comb begin
		count_next  = count_q;
		status_next = ST_OK;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end
		if (in_ch.cmd == CMD_INSERT) begin
			status_next = full ? ST_FULL : ST_OK;
		end else begin
			status_next = empty ? ST_EMPTY : ST_OK;
		end
	end

	// Control state: held count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register, loaded on each command transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_next;
			popped_q      <= do_rem ? cell_entry[0] : entry_t'('0);
			entry_count_q <= 5'(count_next);
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = status_q;
	assign out_ch.popped_id       = popped_q.id;
	assign out_ch.popped_priority = popped_q.prio;
	assign out_ch.entry_count     = entry_count_q;

endmodule

@@ src/spq_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the queue's channels and checks result consistency over time.
// ----------------------------------------------------------------------------
`include "sorted_priority_ready_queue_unit_assert.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [7:0] popped_id,
	input logic [7:0] popped_priority,
	input logic [4:0] entry_count
);

	// A stalled result holds its whole payload.
	`SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(popped_id) && $stable(popped_priority)
		&& $stable(entry_count), "stalled result changed")

	// Every command transfer yields a result in the next cycle.
	`SPQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid,
		"command transfer gave no result")

	// A rejected insert reports a full queue and no popped entry.
	`SPQ_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL),
		(entry_count == 5'(DEPTH)) && (popped_id == 8'd0) && (popped_priority == 8'd0),
		"full status with inconsistent fields")

	// An empty remove reports a zero count and no popped entry.
	`SPQ_ASSERT_NOW(a_empty_count, out_valid && (status == ST_EMPTY),
		(entry_count == 5'd0) && (popped_id == 8'd0) && (popped_priority == 8'd0),
		"empty status with inconsistent fields")

endmodule

bind sorted_priority_ready_queue_unit spq_checker u_spq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.status          (out_ch.status),
	.popped_id       (out_ch.popped_id),
	.popped_priority (out_ch.popped_priority),
	.entry_count     (out_ch.entry_count)
);

@@ tb/tb_sorted_priority_ready_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority ready queue testbench
// Drives insert and remove commands into the queue and checks every result
// against a behavioral queue kept in the testbench. It covers priority order,
// arrival order among equal priorities, inserts into a full queue, removes
// from an empty queue, a long stall on the result side, and random traffic
// with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_priority_ready_queue_unit;
	import spq_pkg::*;

	// Expected fields of one result.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] popped_id;
		logic [7:0] popped_priority;
		logic [4:0] entry_count;
	} queue_result_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTED = 40;

	logic clk;
	logic arst_n;

	spq_in_if  in_ch();
	spq_out_if out_ch();

	// Behavioral copy of the queue contents.
	entry_t queue_model[DEPTH];
	int     model_len;

	// Results still owed by the block, oldest first.
	queue_result_t pending_results[$];

	int  error_count;
	int  cycle_count;
	int  result_count;
	int  insert_count;
	int  pop_count;
	int  full_count;
	int  empty_count;
	int  hold_left;
	bit  tx_idle_on;
	bit  rx_stall_on;

	sorted_priority_ready_queue_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("tb_sorted_priority_ready_queue_unit NOT OK");
			$finish;
		end
	end

	// Applies one command to the behavioral queue and returns the result it owes.
	function automatic queue_result_t apply_command(logic cmd, logic [7:0] id,
		logic [7:0] prio);
		queue_result_t r;
		int pos;
		int i;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			if (model_len >= DEPTH) begin
				r.status = ST_FULL;
				full_count++;
			end else begin
				// The new entry goes behind every entry of greater or equal priority.
				pos = model_len;
				for (i = 0; i < model_len && pos == model_len; i++) begin
					if (prio > queue_model[i].prio)
						pos = i;
				end
				for (i = model_len; i > pos; i--)
					queue_model[i] = queue_model[i - 1];
				queue_model[pos].id = id;
				queue_model[pos].prio = prio;
				model_len++;
				insert_count++;
			end
		end else if (model_len == 0) begin
			r.status = ST_EMPTY;
			empty_count++;
		end else begin
			r.popped_id = queue_model[0].id;
			r.popped_priority = queue_model[0].prio;
			for (i = 0; i + 1 < model_len; i++)
				queue_model[i] = queue_model[i + 1];
			model_len--;
			pop_count++;
		end
		r.entry_count = 5'(model_len);
		return r;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string field, int got, int want);
		begin
			error_count++;
			if (error_count <= MAX_PRINTED)
				$display("Mismatch on %s at result %0d: got %0d, expected %0d", field,
					result_count, got, want);
		end
	endtask

	// Offers one command and waits for its transfer, after an optional idle burst.
	task automatic send_command(logic cmd, logic [7:0] id, logic [7:0] prio);
		int gap;
		begin
			if (tx_idle_on && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 16);
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.cmd <= cmd;
			in_ch.process_id <= id;
			in_ch.process_priority <= prio;
			@(posedge clk);
			while (!in_ch.ready)
				@(posedge clk);
			pending_results.push_back(apply_command(cmd, id, prio));
		end
	endtask

	// Result side ready: a long hold-off when asked, else random stall bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 16) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Compares each result transfer with the oldest expectation.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_PRINTED)
					$display("Unexpected result %0d with no command outstanding",
						result_count);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.status !== want.status)
					report_mismatch("status", out_ch.status, want.status);
				if (out_ch.popped_id !== want.popped_id)
					report_mismatch("popped_id", out_ch.popped_id, want.popped_id);
				if (out_ch.popped_priority !== want.popped_priority)
					report_mismatch("popped_priority", out_ch.popped_priority,
						want.popped_priority);
				if (out_ch.entry_count !== want.entry_count)
					report_mismatch("entry_count", out_ch.entry_count, want.entry_count);
			end
		end
	end

	// A remove on the empty queue, with all ignored fields at their top values.
	task automatic test_remove_from_empty();
		begin
			send_command(CMD_REMOVE, 8'hFF, 8'hFF);
		end
	endtask

	// Extreme priorities and ties, then drained to show the exit order.
	task automatic test_priority_order_and_ties();
		begin
			send_command(CMD_INSERT, 8'h00, 8'h00);
			send_command(CMD_INSERT, 8'hFF, 8'hFF);
			send_command(CMD_INSERT, 8'h11, 8'h80);
			send_command(CMD_INSERT, 8'h22, 8'h80);
			send_command(CMD_INSERT, 8'h33, 8'hFF);
			repeat (5) send_command(CMD_REMOVE, 8'h00, 8'h00);
		end
	endtask

	// Fills every slot, then offers one more insert that must be dropped.
	task automatic test_insert_when_full();
		begin
			repeat (DEPTH) send_command(CMD_INSERT, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 7)));
			send_command(CMD_INSERT, 8'hA5, 8'hFF);
		end
	endtask

	// The receiver holds off for a long stretch while commands keep being offered.
	task automatic test_result_backpressure();
		int i;
		begin
			tx_idle_on = 1'b0;
			hold_left = 300;
			for (i = 0; i < 24; i++) begin
				if (i < 12)
					send_command(CMD_REMOVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				else
					send_command(CMD_INSERT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Random commands with a given insert share; narrow priorities make many ties.
	task automatic test_random_traffic(int n_items, int insert_pct, bit narrow_prio);
		int i;
		logic cmd;
		logic [7:0] prio;
		begin
			for (i = 0; i < n_items; i++) begin
				cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
				if (!narrow_prio)
					prio = 8'($urandom_range(0, 255));
				else if ($urandom_range(0, 1) == 1)
					prio = 8'($urandom_range(252, 255));
				else
					prio = 8'($urandom_range(0, 3));
				send_command(cmd, 8'($urandom_range(0, 255)), prio);
			end
		end
	endtask

	// Final stretch with both channels running flat out.
	task automatic test_unthrottled_traffic();
		begin
			tx_idle_on = 1'b0;
			rx_stall_on = 1'b0;
			test_random_traffic(60, 70, 1'b1);
			test_random_traffic(60, 30, 1'b0);
		end
	endtask

	// Test sequence.
	initial begin
		int phase;
		int drain_wait;
		error_count = 0;
		cycle_count = 0;
		result_count = 0;
		insert_count = 0;
		pop_count = 0;
		full_count = 0;
		empty_count = 0;
		hold_left = 0;
		model_len = 0;
		tx_idle_on = 1'b1;
		rx_stall_on = 1'b1;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= CMD_INSERT;
		in_ch.process_id <= 8'h00;
		in_ch.process_priority <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_remove_from_empty();
		test_priority_order_and_ties();
		test_insert_when_full();
		test_result_backpressure();

		// Alternate fill-heavy, drain-heavy and balanced phases with varied idling.
		for (phase = 0; phase < 10; phase++) begin
			tx_idle_on = (phase % 3 != 2);
			rx_stall_on = (phase % 4 != 1);
			test_random_traffic(108, (phase % 3 == 0) ? 75 : ((phase % 3 == 1) ? 25 : 50),
				phase[0]);
		end
		test_unthrottled_traffic();
		in_ch.valid <= 1'b0;

		// Wait for every owed result, then watch for stray ones.
		while (pending_results.size() != 0)
			@(posedge clk);
		drain_wait = 8;
		repeat (drain_wait) @(posedge clk);

		$display("Checked %0d results: %0d inserts, %0d pops, %0d inserts dropped when full,",
			result_count, insert_count, pop_count, full_count);
		$display("%0d removes on an empty queue, one long result stall, %0d mismatches.",
			empty_count, error_count);
		if (error_count == 0)
			$display("tb_sorted_priority_ready_queue_unit OK");
		else
			$display("tb_sorted_priority_ready_queue_unit NOT OK");
		$finish;
	end

endmodule
